### hdl/lfu_pkg.sv
// lfu_pkg: shared types and constants for the lfu cache with lru tie-break
// holds request/response word structs, sequencer state enum and sizing constants
// depends on nothing
package lfu_pkg;

    localparam int LFU_ENTRIES = 16;
    localparam int LFU_IDX_W   = (LFU_ENTRIES > 1) ? $clog2(LFU_ENTRIES) : 1;
    localparam int LFU_OCC_W   = $clog2(LFU_ENTRIES + 1);
    localparam int LFU_CAP_W   = 5;
    localparam int LFU_CMP_W   = (LFU_OCC_W > LFU_CAP_W) ? LFU_OCC_W : LFU_CAP_W;
    localparam int LFU_KEY_W   = 32;
    localparam int LFU_DATA_W  = 32;
    localparam int LFU_CNT_W   = 32;
    localparam int LFU_TOUCH_W = 64;

    localparam logic [LFU_CAP_W-1:0] LFU_CAP_RESET = LFU_CAP_W'(16);

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    typedef struct packed {
        logic                  func;
        logic [LFU_KEY_W-1:0]  lookup_key;
        logic [LFU_DATA_W-1:0] store_value;
    } t_lfu_req;

    typedef struct packed {
        logic                  found;
        logic [LFU_DATA_W-1:0] read_value;
        logic                  evicted;
        logic [LFU_KEY_W-1:0]  evicted_key;
    } t_lfu_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_lfu_state;

endpackage

### hdl/lfu_cache_with_lru_tiebreak_top.sv
// lfu_cache_with_lru_tiebreak_top: key-value cache, least-frequently-used replacement
// ties broken by least recent touch; one entry scanned per cycle by a shared compare unit
// depends on lfu_pkg
//
//  channel   signals                                  handshake
//  --------  ---------------------------------------  ---------------------------------
//  request   start, i_req (t_lfu_req), busy           word taken when start & !busy
//  response  o_done, o_rsp (t_lfu_rsp)                one-cycle strobe, no backpressure
//  config    i_cfg_valid, i_cfg_data, o_cfg_ready     capacity written when valid & ready
//
//  every word passes through the accept edge, the scan (one slot per cycle through
//  the shared key/victim compare) and the update state that writes the slot
//  the response strobe shows in the cycle after the update, with busy already low
//  reset (synchronous, active low) clears valid bits, touch clock, capacity to 16
//  and the sequencer; no clearing pass is needed since valid bits live in flops
//  the response side cannot stall, so nothing ever waits on the receiver
module lfu_cache_with_lru_tiebreak_top
    import lfu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request
    input  logic                 start,
    input  t_lfu_req             i_req,
    output logic                 busy,
    // response
    output logic                 o_done,
    output t_lfu_rsp             o_rsp,
    // capacity register
    input  logic                 i_cfg_valid,
    input  logic [LFU_CAP_W-1:0] i_cfg_data,
    output logic                 o_cfg_ready
);

    // slot storage: valid bits in resettable flops, the rest written before read
    logic [LFU_ENTRIES-1:0]  r_valid;
    logic [LFU_KEY_W-1:0]    r_slot_key   [LFU_ENTRIES];
    logic [LFU_DATA_W-1:0]   r_slot_data  [LFU_ENTRIES];
    logic [LFU_CNT_W-1:0]    r_use_count  [LFU_ENTRIES];
    logic [LFU_TOUCH_W-1:0]  r_last_touch [LFU_ENTRIES];

    logic [LFU_TOUCH_W-1:0]  r_touch_clk;
    logic [LFU_CAP_W-1:0]    r_cap;

    // sequencer
    t_lfu_state              r_state, n_state;
    logic [LFU_IDX_W-1:0]    r_idx;
    logic                    scan_en;
    logic                    upd_en;
    logic                    scan_last;

    // latched request
    t_lfu_req                r_req;

    // scan results
    logic                    r_hit;
    logic [LFU_IDX_W-1:0]    r_hit_idx;
    logic [LFU_DATA_W-1:0]   r_hit_data;
    logic [LFU_CNT_W-1:0]    r_hit_cnt;
    logic                    r_vic_vld;
    logic [LFU_IDX_W-1:0]    r_vic_idx;
    logic [LFU_KEY_W-1:0]    r_vic_key;
    logic [LFU_CNT_W-1:0]    r_vic_cnt;
    logic [LFU_TOUCH_W-1:0]  r_vic_touch;
    logic                    r_free_vld;
    logic [LFU_IDX_W-1:0]    r_free_idx;
    logic [LFU_OCC_W-1:0]    r_occ;

    // output registers
    logic                    r_done;
    t_lfu_rsp                r_rsp;

    // shared compare unit, fed from the slot under the scan index
    logic                    cur_valid;
    logic [LFU_KEY_W-1:0]    cur_key;
    logic [LFU_CNT_W-1:0]    cur_cnt;
    logic [LFU_TOUCH_W-1:0]  cur_touch;
    logic                    key_match;
    logic                    older_lower;

    // update decisions
    logic [LFU_CMP_W-1:0]    eff_cap;
    logic                    full;
    logic                    wen;
    logic [LFU_IDX_W-1:0]    widx;
    logic [LFU_DATA_W-1:0]   wdata;
    logic [LFU_CNT_W-1:0]    wcnt;
    logic [LFU_TOUCH_W-1:0]  touch_next;
    t_lfu_rsp                rsp_next;

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = !busy;
    assign o_done      = r_done;
    assign o_rsp       = r_rsp;

    assign scan_last = (r_idx == LFU_IDX_W'(LFU_ENTRIES - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state decode
    always_comb begin
        scan_en = 1'b0;
        upd_en  = 1'b0;
        case (r_state)
            ST_IDLE:   begin end
            ST_SCAN:   scan_en = 1'b1;
            ST_UPDATE: upd_en  = 1'b1;
            default:   begin end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // scan index runs 0..ENTRIES-1 during the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (scan_en) begin
            r_idx <= scan_last ? '0 : r_idx + LFU_IDX_W'(1);
        end else begin
            r_idx <= '0;
        end
    end

    // capacity register, only written while idle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= LFU_CAP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cap <= i_cfg_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    // shared compare: key equality plus {count, touch} ordering against the victim
    assign cur_valid   = r_valid[r_idx];
    assign cur_key     = r_slot_key[r_idx];
    assign cur_cnt     = r_use_count[r_idx];
    assign cur_touch   = r_last_touch[r_idx];
    assign key_match   = (cur_key == r_req.lookup_key);
    assign older_lower = ({cur_cnt, cur_touch} < {r_vic_cnt, r_vic_touch});

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_hit      <= 1'b0;
            r_vic_vld  <= 1'b0;
            r_free_vld <= 1'b0;
            r_occ      <= '0;
        end else if (scan_en) begin
            if (cur_valid) begin
                r_occ <= r_occ + LFU_OCC_W'(1);
                if (key_match) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_idx;
                    r_hit_data <= r_slot_data[r_idx];
                    r_hit_cnt  <= cur_cnt;
                end
                if (!r_vic_vld || older_lower) begin
                    r_vic_vld   <= 1'b1;
                    r_vic_idx   <= r_idx;
                    r_vic_key   <= cur_key;
                    r_vic_cnt   <= cur_cnt;
                    r_vic_touch <= cur_touch;
                end
            end else if (!r_free_vld) begin
                r_free_vld <= 1'b1;
                r_free_idx <= r_idx;
            end
        end
    end

    // update decisions from the captured scan results
    assign eff_cap    = (LFU_CMP_W'(r_cap) > LFU_CMP_W'(LFU_ENTRIES))
                        ? LFU_CMP_W'(LFU_ENTRIES) : LFU_CMP_W'(r_cap);
    assign full       = (LFU_CMP_W'(r_occ) >= eff_cap);
    assign touch_next = r_touch_clk + LFU_TOUCH_W'(1);

    always_comb begin
        wen      = 1'b0;
        widx     = r_hit_idx;
        wdata    = r_req.store_value;
        wcnt     = LFU_CNT_W'(1);

        rsp_next             = '0;
        rsp_next.found       = r_hit;

        if (r_req.func == FUNC_GET) begin
            if (r_hit) begin
                wen                 = 1'b1;
                wdata               = r_hit_data;
                rsp_next.read_value = r_hit_data;
            end
        end else if (eff_cap != '0) begin
            if (r_hit) begin
                wen = 1'b1;
            end else if (full && r_vic_vld) begin
                // victim slot is refilled with the new key
                wen                  = 1'b1;
                widx                 = r_vic_idx;
                rsp_next.evicted     = 1'b1;
                rsp_next.evicted_key = r_vic_key;
            end else if (r_free_vld) begin
                wen  = 1'b1;
                widx = r_free_idx;
            end
        end

        // hit bumps the count, saturating; a fresh insert starts at one
        if (r_hit) begin
            wcnt = (r_hit_cnt == '1) ? r_hit_cnt : r_hit_cnt + LFU_CNT_W'(1);
        end

        wen = wen & upd_en;
    end

    // slot storage write port; evict and refill hit the same slot, so valid stays set
    always_ff @(posedge i_clk) begin
        if (wen) begin
            r_slot_key[widx]   <= r_req.lookup_key;
            r_slot_data[widx]  <= wdata;
            r_use_count[widx]  <= wcnt;
            r_last_touch[widx] <= touch_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_touch_clk <= '0;
        end else if (wen) begin
            r_valid[widx] <= 1'b1;
            r_touch_clk   <= touch_next;
        end
    end

    // response word, one-cycle strobe after the update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= upd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_en) begin
            r_rsp <= rsp_next;
        end
    end

endmodule

### sim/testbench.sv
// testbench: self-checking bench for lfu_cache_with_lru_tiebreak_top
// drives get/put words and capacity writes, predicts every response word in-bench
// depends on lfu_pkg and the cache top level
`timescale 1ns / 100ps

module testbench;
    import lfu_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 40;
    localparam int PHASE_WORDS    = 85;

    // one entry of the stimulus queue: a request word or a capacity write
    typedef struct {
        bit                   is_cfg;
        t_lfu_req             req;
        logic [LFU_CAP_W-1:0] cap;
    } t_pending_op;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    t_lfu_req             i_req;
    logic                 busy;
    logic                 o_done;
    t_lfu_rsp             o_rsp;
    logic                 i_cfg_valid;
    logic [LFU_CAP_W-1:0] i_cfg_data;
    logic                 o_cfg_ready;

    t_pending_op pending_ops[$];
    t_lfu_rsp    awaited_rsps[$];

    // shadow copy of the cache contents
    logic                   shadow_valid [LFU_ENTRIES];
    logic [LFU_KEY_W-1:0]   shadow_key   [LFU_ENTRIES];
    logic [LFU_DATA_W-1:0]  shadow_data  [LFU_ENTRIES];
    logic [LFU_CNT_W-1:0]   shadow_count [LFU_ENTRIES];
    logic [LFU_TOUCH_W-1:0] shadow_touch [LFU_ENTRIES];
    logic [LFU_TOUCH_W-1:0] shadow_clock;
    logic [LFU_CAP_W-1:0]   shadow_capacity;

    int error_count = 0;
    int idle_cycles = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    bit req_taken   = 0;
    bit cfg_taken   = 0;

    lfu_cache_with_lru_tiebreak_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_req       (i_req),
        .busy        (busy),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // raise the touch clock and stamp the slot with it
    function automatic void stamp_slot(input int s);
        shadow_clock = shadow_clock + 1;
        shadow_touch[s] = shadow_clock;
    endfunction

    // hit path: count saturates at all ones, recency always refreshed
    function automatic void bump_slot(input int s);
        if (shadow_count[s] != '1) begin
            shadow_count[s] = shadow_count[s] + 1;
        end
        stamp_slot(s);
    endfunction

    // full cache access: returns the response word and updates the shadow state
    function automatic t_lfu_rsp cache_access(input t_lfu_req r);
        t_lfu_rsp rsp;
        int       hit_slot;
        int       free_slot;
        int       victim;
        int       occupancy;
        int       limit;
        int       i;
        hit_slot  = -1;
        free_slot = -1;
        victim    = -1;
        occupancy = 0;
        // capacities above the slot count behave as a full-size cache
        limit = (shadow_capacity > LFU_ENTRIES) ? LFU_ENTRIES : int'(shadow_capacity);
        for (i = 0; i < LFU_ENTRIES; i++) begin
            if (shadow_valid[i]) begin
                occupancy++;
                if (shadow_key[i] == r.lookup_key) begin
                    hit_slot = i;
                end
                // lowest count wins, oldest touch breaks ties
                if (victim < 0 || shadow_count[i] < shadow_count[victim] ||
                    (shadow_count[i] == shadow_count[victim] &&
                     shadow_touch[i] < shadow_touch[victim])) begin
                    victim = i;
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        rsp             = '0;
        rsp.found       = (hit_slot >= 0);
        if (r.func == FUNC_GET) begin
            if (hit_slot >= 0) begin
                rsp.read_value = shadow_data[hit_slot];
                bump_slot(hit_slot);
            end
            return rsp;
        end
        // zero capacity turns a put into a no-op, found still reported
        if (limit == 0) begin
            return rsp;
        end
        if (hit_slot >= 0) begin
            shadow_data[hit_slot] = r.store_value;
            bump_slot(hit_slot);
            return rsp;
        end
        // one eviction at most, even when occupancy sits above a lowered capacity
        if (occupancy >= limit && victim >= 0) begin
            rsp.evicted         = 1'b1;
            rsp.evicted_key     = shadow_key[victim];
            shadow_valid[victim] = 1'b0;
            free_slot           = victim;
        end
        if (free_slot >= 0) begin
            shadow_valid[free_slot] = 1'b1;
            shadow_key[free_slot]   = r.lookup_key;
            shadow_data[free_slot]  = r.store_value;
            shadow_count[free_slot] = 1;
            stamp_slot(free_slot);
        end
        return rsp;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t mismatch on %s: expected %h actual %h", $time, name,
                     exp_val, act_val);
            error_count++;
        end
    endfunction

    function automatic void push_op(input logic func, input logic [31:0] key,
                                    input logic [31:0] value);
        t_pending_op op;
        op.is_cfg            = 1'b0;
        op.req.func          = func;
        op.req.lookup_key    = key;
        op.req.store_value   = value;
        op.cap               = '0;
        pending_ops.push_back(op);
    endfunction

    function automatic void push_cap(input logic [LFU_CAP_W-1:0] cap);
        t_pending_op op;
        op.is_cfg = 1'b1;
        op.req    = '0;
        op.cap    = cap;
        pending_ops.push_back(op);
    endfunction

    // monitor: results checked before the new word is predicted, capacity
    // tracked on its own handshake, watchdog on any kind of progress
    always @(posedge i_clk) begin
        t_lfu_rsp exp_rsp;
        bit       progress;
        progress  = 1'b0;
        req_taken = 1'b0;
        cfg_taken = 1'b0;
        if (!i_rst_n) begin
            for (int i = 0; i < LFU_ENTRIES; i++) begin
                shadow_valid[i] = 1'b0;
                shadow_key[i]   = '0;
                shadow_data[i]  = '0;
                shadow_count[i] = '0;
                shadow_touch[i] = '0;
            end
            shadow_clock    = '0;
            shadow_capacity = LFU_CAP_RESET;
            idle_cycles     = 0;
        end else begin
            if (o_done) begin
                progress = 1'b1;
                if (awaited_rsps.size() == 0) begin
                    $display("%0t unexpected response word: expected none actual %h",
                             $time, o_rsp);
                    error_count++;
                end else begin
                    exp_rsp = awaited_rsps.pop_front();
                    check_field("found", 32'(exp_rsp.found), 32'(o_rsp.found));
                    check_field("read_value", exp_rsp.read_value, o_rsp.read_value);
                    check_field("evicted", 32'(exp_rsp.evicted), 32'(o_rsp.evicted));
                    check_field("evicted_key", exp_rsp.evicted_key, o_rsp.evicted_key);
                end
            end
            if (start && !busy) begin
                progress  = 1'b1;
                req_taken = 1'b1;
                awaited_rsps.push_back(cache_access(i_req));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                progress        = 1'b1;
                cfg_taken       = 1'b1;
                shadow_capacity = i_cfg_data;
            end
            idle_cycles = progress ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // driver: bursts of request words with random gaps; a capacity write
    // waits until the cache has answered everything it took
    always @(negedge i_clk) begin
        logic drive_start;
        logic drive_cfg;
        drive_start = start && !req_taken;
        drive_cfg   = i_cfg_valid && !cfg_taken;
        if (i_rst_n && !drive_start && !drive_cfg) begin
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
            end else if (pending_ops.size() != 0) begin
                if (pending_ops[0].is_cfg) begin
                    if (awaited_rsps.size() == 0 && !busy) begin
                        i_cfg_data <= pending_ops[0].cap;
                        drive_cfg   = 1'b1;
                        void'(pending_ops.pop_front());
                    end
                end else begin
                    i_req      <= pending_ops[0].req;
                    drive_start = 1'b1;
                    void'(pending_ops.pop_front());
                    if (burst_left == 0) begin
                        // a quarter of the bursts run back to back with no gap
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 :
                                     $urandom_range(1, 30);
                    end else begin
                        burst_left = burst_left - 1;
                    end
                end
            end
        end
        start       <= drive_start;
        i_cfg_valid <= drive_cfg;
    end

    initial begin
        logic [31:0]          key_pool[$];
        logic [LFU_CAP_W-1:0] phase_caps[$];
        logic [31:0]          key;
        logic [31:0]          value;
        int                   pool_size;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;

        // directed: empty miss, extreme keys and values, update, eviction order,
        // zero capacity, capacity below occupancy, saturated capacity, lru tie
        push_op(FUNC_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        push_op(FUNC_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
        push_op(FUNC_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(FUNC_GET, 32'h0000_0000, 32'h0000_0000);
        push_op(FUNC_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(FUNC_PUT, 32'h0000_0000, 32'h1234_5678);
        push_op(FUNC_GET, 32'h0000_0000, 32'h0);
        push_cap(LFU_CAP_W'(2));
        push_op(FUNC_PUT, 32'h5, 32'h5555_5555);
        push_op(FUNC_PUT, 32'h6, 32'hAAAA_AAAA);
        push_op(FUNC_GET, 32'h6, 32'h0);
        push_cap(LFU_CAP_W'(0));
        push_op(FUNC_PUT, 32'h7, 32'h7777_7777);
        push_op(FUNC_PUT, 32'h0, 32'h1);
        push_op(FUNC_GET, 32'h0, 32'h0);
        push_cap(LFU_CAP_W'(1));
        push_op(FUNC_PUT, 32'h8, 32'h8888_8888);
        push_op(FUNC_PUT, 32'h0, 32'h0000_AAAA);
        push_cap(LFU_CAP_W'(31));
        push_op(FUNC_PUT, 32'h9, 32'h9999_9999);
        push_op(FUNC_PUT, 32'hA, 32'hAAAA_0000);
        push_cap(LFU_CAP_W'(3));
        push_op(FUNC_PUT, 32'hB, 32'hBBBB_BBBB);
        push_op(FUNC_GET, 32'h9, 32'h0);
        push_op(FUNC_PUT, 32'hC, 32'hCCCC_CCCC);

        // random phases: keys mostly from a small pool so hits, updates and
        // evictions are common; now and then a fresh full-range key
        phase_caps = '{LFU_CAP_W'(16), LFU_CAP_W'(4), LFU_CAP_W'(1), LFU_CAP_W'(0),
                       LFU_CAP_W'(31), LFU_CAP_W'(2), LFU_CAP_W'(17),
                       LFU_CAP_W'($urandom_range(0, 31))};
        foreach (phase_caps[p]) begin
            push_cap(phase_caps[p]);
            pool_size = $urandom_range(6, 24);
            key_pool  = '{32'h0000_0000, 32'hFFFF_FFFF};
            while (key_pool.size() < pool_size) begin
                key_pool.push_back($urandom());
            end
            repeat (PHASE_WORDS) begin
                if ($urandom_range(0, 9) == 0) begin
                    key = $urandom();
                end else begin
                    key = key_pool[$urandom_range(0, pool_size - 1)];
                end
                case ($urandom_range(0, 9))
                    0:       value = 32'h0000_0000;
                    1:       value = 32'hFFFF_FFFF;
                    default: value = $urandom();
                endcase
                push_op(($urandom_range(0, 1) == 0) ? FUNC_GET : FUNC_PUT, key, value);
            end
        end

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all words taken, every response seen, then a short tail
        // to catch stray strobes
        while (pending_ops.size() != 0 || start || i_cfg_valid || awaited_rsps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
